// File: src/rc_link_frame_receiver_defines.svh
// assertion macros for the rc link frame receiver
`ifndef RC_LINK_FRAME_RECEIVER_DEFINES_SVH
`define RC_LINK_FRAME_RECEIVER_DEFINES_SVH

`ifndef SYNTH

// plain property check, clocked, disabled in reset
`define RCLFR_ASSERT(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (prop)) else $error(msg);

// condition implies consequence in the same cycle
`define RCLFR_ASSERT_IMP(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |-> (cons)) else $error(msg);

// condition implies consequence in the next cycle
`define RCLFR_ASSERT_NXT(label, clk, rst, cond, cons, msg) \
   label: assert property (@(posedge clk) disable iff (rst) (cond) |=> (cons)) else $error(msg);

`else

`define RCLFR_ASSERT(label, clk, rst, prop, msg)
`define RCLFR_ASSERT_IMP(label, clk, rst, cond, cons, msg)
`define RCLFR_ASSERT_NXT(label, clk, rst, cond, cons, msg)

`endif

`endif

// File: src/rclfr_pkg.sv
// shared types, constants and functions of the rc link frame receiver
`timescale 1ns / 1ps

package rclfr_pkg;

   localparam int BUFFER_BYTES_DEF    = 64;
   localparam int NUM_CHANNELS_DEF    = 16;
   localparam int CHANNEL_BITS_DEF    = 11;
   localparam int LINK_STAT_BYTES_DEF = 10;

   localparam int SILENCE_W   = 20;
   localparam int IDX_W       = 4;
   localparam int VALUE_W     = 12;
   localparam int QUEUE_DEPTH = 2;

   // first payload position in a frame (after address, length, type)
   localparam int FIRST_PAYLOAD = 3;

   localparam logic [SILENCE_W-1:0] SILENCE_MAX   = '1;
   localparam logic [7:0]           TYPE_RC_CHANNELS = 8'h16;
   localparam logic [7:0]           TYPE_LINK_STATS  = 8'h14;
   localparam logic [7:0]           ADDR_BROADCAST   = 8'h00;
   localparam logic [11:0]          CHANNEL_OFFSET   = 12'd880;

   localparam logic [SILENCE_W-1:0] MIN_GAP_RESET  = 20'd1000;
   localparam logic [SILENCE_W-1:0] FAILSAFE_RESET = 20'd100000;
   localparam logic [7:0]           OWN_ADDR_RESET = 8'd200;
   localparam logic [7:0]           CRC_POLY_RESET = 8'hD5;

   typedef enum logic {
      OP_BYTE = 1'b0,
      OP_TICK = 1'b1
   } op_type;

   typedef enum logic [2:0] {
      KIND_CHANNEL   = 3'd0,
      KIND_LINK_STAT = 3'd1,
      KIND_OTHER     = 3'd2,
      KIND_CRC_ERROR = 3'd3,
      KIND_FAILSAFE  = 3'd4
   } kind_type;

   typedef enum logic [1:0] {
      CSR_MIN_GAP  = 2'd0,
      CSR_FAILSAFE = 2'd1,
      CSR_OWN_ADDR = 2'd2,
      CSR_CRC_POLY = 2'd3
   } csr_index_type;

   typedef struct packed {
      logic [SILENCE_W-1:0] min_gap_ticks;
      logic [SILENCE_W-1:0] failsafe_ticks;
      logic [7:0]           own_address;
      logic [7:0]           crc_poly;
   } csr_type;

   // header of one queued job for the back end
   typedef struct packed {
      kind_type   kind;
      logic [7:0] frame_kind;
      logic       in_failsafe;
   } hdr_type;

   // queue status seen by front and back
   typedef struct packed {
      logic full;
      logic empty;
   } qstat_type;

   // crc-8, msb first, one byte
   function automatic logic [7:0] crc_update(input logic [7:0] crc,
                                             input logic [7:0] data,
                                             input logic [7:0] poly);
      logic [7:0] c;
      c = crc ^ data;
      for (int k = 0; k < 8; k++) begin
         c = c[7] ? ({c[6:0], 1'b0} ^ poly) : {c[6:0], 1'b0};
      end
      return c;
   endfunction

   // x*5/8 + 880 by shift and add
   function automatic logic [11:0] scale_channel(input logic [CHANNEL_BITS_DEF-1:0] x);
      logic [13:0] p;
      p = {1'b0, x, 2'b00} + {3'b000, x};
      return {1'b0, p[13:3]} + CHANNEL_OFFSET;
   endfunction

endpackage

// File: src/rc_link_frame_receiver.sv
// top level of the rc link frame receiver: config registers, front, queue, back
`timescale 1ns / 1ps

// result path: a byte that completes a frame or a tick that flips failsafe passes
//    the job queue and back end to the output register, one item a cycle under no stall
// throughput: one input item a cycle while the two-entry job queue has room; a job is
//    loaded, then gives one item a cycle under no stall (up to 16 for rc channels)
// reset: synchronous, active high; clears framing, silence and failsafe state and the
//    queue, loads the config defaults; no clearing pass, the block is ready at once

module rc_link_frame_receiver #(
   parameter int BUFFER_BYTES    = rclfr_pkg::BUFFER_BYTES_DEF,
   parameter int NUM_CHANNELS    = rclfr_pkg::NUM_CHANNELS_DEF,
   parameter int CHANNEL_BITS    = rclfr_pkg::CHANNEL_BITS_DEF,
   parameter int LINK_STAT_BYTES = rclfr_pkg::LINK_STAT_BYTES_DEF
) (
   input  logic                                 clock,
   input  logic                                 reset,
   // input items: received byte or time tick
   input  logic                                 req_valid,
   output logic                                 req_stall,
   input  logic                                 req_operation,
   input  logic [7:0]                           req_rx_byte,
   // result items
   output logic                                 rsp_valid,
   input  logic                                 rsp_stall,
   output logic [2:0]                           rsp_kind,
   output logic [rclfr_pkg::IDX_W-1:0]          rsp_item_index,
   output logic [rclfr_pkg::VALUE_W-1:0]        rsp_item_value,
   output logic [7:0]                           rsp_frame_kind,
   output logic                                 rsp_in_failsafe,
   output logic                                 rsp_last_of_run,
   // config write port
   input  logic                                 csr_we,
   input  logic [1:0]                           csr_index,
   input  logic [rclfr_pkg::SILENCE_W-1:0]      csr_wdata
);

   // payload kept per frame: enough bytes for all channels or all link-stat bytes
   localparam int CH_BYTES  = (NUM_CHANNELS * CHANNEL_BITS + 7) / 8;
   localparam int PAY_BYTES = (CH_BYTES > LINK_STAT_BYTES) ? CH_BYTES : LINK_STAT_BYTES;
   localparam int PAY_BITS  = PAY_BYTES * 8;
   localparam int HW        = $bits(rclfr_pkg::hdr_type);
   localparam int QW        = HW + PAY_BITS;

   rclfr_pkg::csr_type    csr_ff, csr_in;

   logic                  push;
   rclfr_pkg::hdr_type    push_hdr;
   logic [PAY_BITS-1:0]   push_pay;
   logic                  pop;
   logic [QW-1:0]         q_rdata;
   rclfr_pkg::qstat_type  qstat;
   rclfr_pkg::hdr_type    job_hdr;

   // config registers, to be written only while the block is idle; not enforced here
   always_comb begin
      csr_in = csr_ff;
      if (csr_we) begin
         case (csr_index)
            rclfr_pkg::CSR_MIN_GAP:  csr_in.min_gap_ticks  = csr_wdata;
            rclfr_pkg::CSR_FAILSAFE: csr_in.failsafe_ticks = csr_wdata;
            rclfr_pkg::CSR_OWN_ADDR: csr_in.own_address    = csr_wdata[7:0];
            rclfr_pkg::CSR_CRC_POLY: csr_in.crc_poly       = csr_wdata[7:0];
            default:                 csr_in = csr_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         csr_ff.min_gap_ticks  <= rclfr_pkg::MIN_GAP_RESET;
         csr_ff.failsafe_ticks <= rclfr_pkg::FAILSAFE_RESET;
         csr_ff.own_address    <= rclfr_pkg::OWN_ADDR_RESET;
         csr_ff.crc_poly       <= rclfr_pkg::CRC_POLY_RESET;
      end else begin
         csr_ff <= csr_in;
      end
   end

   // front: framing, crc check, silence counter, failsafe, job classification
   rclfr_front #(
      .BUFFER_BYTES (BUFFER_BYTES),
      .PAY_BYTES    (PAY_BYTES)
   ) u_front (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_stall     (req_stall),
      .req_operation (req_operation),
      .req_rx_byte   (req_rx_byte),
      .csr           (csr_ff),
      .qstat         (qstat),
      .push          (push),
      .push_hdr      (push_hdr),
      .push_pay      (push_pay)
   );

   // job queue: header plus frame payload snapshot
   rclfr_queue #(
      .WIDTH (QW)
   ) u_queue (
      .clock (clock),
      .reset (reset),
      .push  (push),
      .wdata ({push_hdr, push_pay}),
      .pop   (pop),
      .rdata (q_rdata),
      .stat  (qstat)
   );

   assign job_hdr = rclfr_pkg::hdr_type'(q_rdata[QW-1 -: HW]);

   // back: one result item a cycle to the output register while not stalled or loading
   rclfr_back #(
      .NUM_CHANNELS    (NUM_CHANNELS),
      .CHANNEL_BITS    (CHANNEL_BITS),
      .LINK_STAT_BYTES (LINK_STAT_BYTES),
      .PAY_BITS        (PAY_BITS)
   ) u_back (
      .clock           (clock),
      .reset           (reset),
      .qstat           (qstat),
      .job_hdr         (job_hdr),
      .job_pay         (q_rdata[PAY_BITS-1:0]),
      .pop             (pop),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_item_index  (rsp_item_index),
      .rsp_item_value  (rsp_item_value),
      .rsp_frame_kind  (rsp_frame_kind),
      .rsp_in_failsafe (rsp_in_failsafe),
      .rsp_last_of_run (rsp_last_of_run)
   );

endmodule

// File: src/rclfr_queue.sv
// two-entry job queue between front and back end
`timescale 1ns / 1ps

module rclfr_queue #(
   parameter int WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  logic [WIDTH-1:0]      wdata,
   input  logic                  pop,
   output logic [WIDTH-1:0]      rdata,
   output rclfr_pkg::qstat_type  stat
);

   localparam int PW = $clog2(rclfr_pkg::QUEUE_DEPTH);
   localparam int CW = $clog2(rclfr_pkg::QUEUE_DEPTH + 1);

   logic [WIDTH-1:0] mem_ff [rclfr_pkg::QUEUE_DEPTH];
   logic [PW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [PW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [CW-1:0]    count_ff, count_in;

   always_comb begin
      wr_ptr_in = push ? wr_ptr_ff + PW'(1) : wr_ptr_ff;
      rd_ptr_in = pop  ? rd_ptr_ff + PW'(1) : rd_ptr_ff;
      count_in  = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem_ff[wr_ptr_ff] <= wdata;
      end
   end

   assign rdata      = mem_ff[rd_ptr_ff];
   assign stat.full  = (count_ff == CW'(rclfr_pkg::QUEUE_DEPTH));
   assign stat.empty = (count_ff == '0);

endmodule

// File: src/rclfr_front.sv
// front end: framing, crc, silence and failsafe tracking, job classification
`timescale 1ns / 1ps

module rclfr_front #(
   parameter int BUFFER_BYTES = rclfr_pkg::BUFFER_BYTES_DEF,
   parameter int PAY_BYTES    = 22
) (
   input  logic                    clock,
   input  logic                    reset,
   input  logic                    req_valid,
   output logic                    req_stall,
   input  logic                    req_operation,
   input  logic [7:0]              req_rx_byte,
   input  rclfr_pkg::csr_type      csr,
   input  rclfr_pkg::qstat_type    qstat,
   output logic                    push,
   output rclfr_pkg::hdr_type      push_hdr,
   output logic [PAY_BYTES*8-1:0]  push_pay
);

   localparam int CW    = $clog2(BUFFER_BYTES + 1);
   localparam int CMP_W = ((CW > 8) ? CW : 8) + 1;

   logic [CW-1:0]                  count_ff, count_in;
   logic [7:0]                     crc_ff, crc_in;
   logic [7:0]                     dl_ff, dl_in;
   logic [7:0]                     len_ff, len_in;
   logic [7:0]                     addr_ff, addr_in;
   logic [7:0]                     type_ff, type_in;
   logic [PAY_BYTES*8-1:0]         pay_ff, pay_in;
   logic [rclfr_pkg::SILENCE_W-1:0] silence_ff, silence_in;
   logic                           fs_ff, fs_in;

   logic                           accept;
   logic                           start_clear;
   logic [CW-1:0]                  pos;
   logic [7:0]                     crc_base, crc_new, dl_now, type_now;
   logic [PAY_BYTES*8-1:0]         pay_wr;
   logic                           finish;
   logic                           addr_ok;
   logic                           fs_new;

   always_comb begin
      accept      = req_valid && !qstat.full;
      start_clear = (silence_ff > csr.min_gap_ticks) || (count_ff >= CW'(BUFFER_BYTES));
      pos         = start_clear ? '0 : count_ff;
      crc_base    = start_clear ? 8'h00 : crc_ff;
      dl_now      = (pos == CW'(2)) ? len_ff : dl_ff;
      type_now    = (pos == CW'(2)) ? req_rx_byte : type_ff;

      // payload lanes at fixed positions, unreceived lanes stay zero
      pay_wr = start_clear ? '0 : pay_ff;
      for (int j = 0; j < PAY_BYTES; j++) begin
         if (pos == CW'(rclfr_pkg::FIRST_PAYLOAD + j)) begin
            pay_wr[j*8 +: 8] = req_rx_byte;
         end
      end

      if ((pos >= CW'(2)) && (CMP_W'(pos) <= CMP_W'(dl_now))) begin
         crc_new = rclfr_pkg::crc_update(crc_base, req_rx_byte, csr.crc_poly);
      end else begin
         crc_new = crc_base;
      end

      finish  = (pos >= CW'(2)) && (CMP_W'(pos) == CMP_W'(dl_now) + CMP_W'(1));
      addr_ok = (addr_ff == rclfr_pkg::ADDR_BROADCAST) || (addr_ff == csr.own_address);

      silence_in = silence_ff;
      count_in   = count_ff;
      crc_in     = crc_ff;
      dl_in      = dl_ff;
      len_in     = len_ff;
      addr_in    = addr_ff;
      type_in    = type_ff;
      pay_in     = pay_ff;
      fs_in      = fs_ff;
      fs_new     = fs_ff;

      push                 = 1'b0;
      push_hdr.kind        = rclfr_pkg::KIND_OTHER;
      push_hdr.frame_kind  = type_now;
      push_hdr.in_failsafe = fs_ff;
      push_pay             = pay_wr;

      if (accept && (req_operation == rclfr_pkg::OP_BYTE)) begin
         silence_in = '0;
         dl_in      = dl_now;
         type_in    = type_now;
         if (pos == '0) begin
            addr_in = req_rx_byte;
         end
         if (pos == CW'(1)) begin
            len_in = req_rx_byte;
         end
         if (finish) begin
            push     = 1'b1;
            count_in = '0;
            crc_in   = 8'h00;
            pay_in   = '0;
            if (crc_new != req_rx_byte) begin
               push_hdr.kind = rclfr_pkg::KIND_CRC_ERROR;
            end else if (addr_ok && (type_now == rclfr_pkg::TYPE_RC_CHANNELS)) begin
               push_hdr.kind = rclfr_pkg::KIND_CHANNEL;
            end else if (addr_ok && (type_now == rclfr_pkg::TYPE_LINK_STATS)) begin
               push_hdr.kind = rclfr_pkg::KIND_LINK_STAT;
            end else begin
               push_hdr.kind = rclfr_pkg::KIND_OTHER;
            end
         end else begin
            count_in = pos + CW'(1);
            crc_in   = crc_new;
            pay_in   = pay_wr;
         end
      end else if (accept) begin
         if (silence_ff != rclfr_pkg::SILENCE_MAX) begin
            silence_in = silence_ff + rclfr_pkg::SILENCE_W'(1);
         end
         fs_new = (silence_in > csr.failsafe_ticks);
         if (fs_new != fs_ff) begin
            fs_in                = fs_new;
            push                 = 1'b1;
            push_hdr.kind        = rclfr_pkg::KIND_FAILSAFE;
            push_hdr.frame_kind  = 8'h00;
            push_hdr.in_failsafe = fs_new;
         end
      end
   end

   assign req_stall = qstat.full;

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff   <= '0;
         crc_ff     <= 8'h00;
         dl_ff      <= 8'h00;
         pay_ff     <= '0;
         silence_ff <= '0;
         fs_ff      <= 1'b0;
      end else begin
         count_ff   <= count_in;
         crc_ff     <= crc_in;
         dl_ff      <= dl_in;
         pay_ff     <= pay_in;
         silence_ff <= silence_in;
         fs_ff      <= fs_in;
      end
   end

   always_ff @(posedge clock) begin
      len_ff  <= len_in;
      addr_ff <= addr_in;
      type_ff <= type_in;
   end

endmodule

// File: src/rclfr_back.sv
// back end: unpacks queued jobs into result items through an output register
`timescale 1ns / 1ps
`include "rc_link_frame_receiver_defines.svh"

module rclfr_back #(
   parameter int NUM_CHANNELS    = rclfr_pkg::NUM_CHANNELS_DEF,
   parameter int CHANNEL_BITS    = rclfr_pkg::CHANNEL_BITS_DEF,
   parameter int LINK_STAT_BYTES = rclfr_pkg::LINK_STAT_BYTES_DEF,
   parameter int PAY_BITS        = 176
) (
   input  logic                              clock,
   input  logic                              reset,
   input  rclfr_pkg::qstat_type              qstat,
   input  rclfr_pkg::hdr_type                job_hdr,
   input  logic [PAY_BITS-1:0]               job_pay,
   output logic                              pop,
   output logic                              rsp_valid,
   input  logic                              rsp_stall,
   output logic [2:0]                        rsp_kind,
   output logic [rclfr_pkg::IDX_W-1:0]       rsp_item_index,
   output logic [rclfr_pkg::VALUE_W-1:0]     rsp_item_value,
   output logic [7:0]                        rsp_frame_kind,
   output logic                              rsp_in_failsafe,
   output logic                              rsp_last_of_run
);

   localparam int IW = rclfr_pkg::IDX_W;
   localparam int VW = rclfr_pkg::VALUE_W;

   logic                   busy_ff, busy_in;
   rclfr_pkg::hdr_type     hdr_ff, hdr_in;
   logic [PAY_BITS-1:0]    shift_ff, shift_in;
   logic [IW-1:0]          idx_ff, idx_in;

   logic                   rvalid_ff, rvalid_in;
   rclfr_pkg::kind_type    rkind_ff, rkind_in;
   logic [IW-1:0]          ridx_ff, ridx_in;
   logic [VW-1:0]          rvalue_ff, rvalue_in;
   logic [7:0]             rfk_ff, rfk_in;
   logic                   rfs_ff, rfs_in;
   logic                   rlast_ff, rlast_in;

   logic                   out_free;
   logic                   last;

   always_comb begin
      out_free = !rvalid_ff || !rsp_stall;
      pop      = !busy_ff && !qstat.empty;

      case (hdr_ff.kind)
         rclfr_pkg::KIND_CHANNEL:   last = (idx_ff == IW'(NUM_CHANNELS - 1));
         rclfr_pkg::KIND_LINK_STAT: last = (idx_ff == IW'(LINK_STAT_BYTES - 1));
         default:                   last = 1'b1;
      endcase

      busy_in  = busy_ff;
      hdr_in   = hdr_ff;
      shift_in = shift_ff;
      idx_in   = idx_ff;

      rvalid_in = rvalid_ff;
      rkind_in  = rkind_ff;
      ridx_in   = ridx_ff;
      rvalue_in = rvalue_ff;
      rfk_in    = rfk_ff;
      rfs_in    = rfs_ff;
      rlast_in  = rlast_ff;

      if (out_free) begin
         rvalid_in = busy_ff;
      end

      if (pop) begin
         busy_in  = 1'b1;
         hdr_in   = job_hdr;
         shift_in = job_pay;
         idx_in   = '0;
      end else if (busy_ff && out_free) begin
         rkind_in = hdr_ff.kind;
         rfk_in   = hdr_ff.frame_kind;
         rfs_in   = hdr_ff.in_failsafe;
         rlast_in = last;
         case (hdr_ff.kind)
            rclfr_pkg::KIND_CHANNEL: begin
               ridx_in   = idx_ff;
               rvalue_in = rclfr_pkg::scale_channel(shift_ff[CHANNEL_BITS-1:0]);
               shift_in  = shift_ff >> CHANNEL_BITS;
            end
            rclfr_pkg::KIND_LINK_STAT: begin
               ridx_in   = idx_ff;
               rvalue_in = VW'(shift_ff[7:0]);
               shift_in  = shift_ff >> 8;
            end
            default: begin
               ridx_in   = '0;
               rvalue_in = '0;
            end
         endcase
         idx_in  = idx_ff + IW'(1);
         busy_in = !last;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff   <= 1'b0;
         rvalid_ff <= 1'b0;
      end else begin
         busy_ff   <= busy_in;
         rvalid_ff <= rvalid_in;
      end
   end

   always_ff @(posedge clock) begin
      hdr_ff    <= hdr_in;
      shift_ff  <= shift_in;
      idx_ff    <= idx_in;
      rkind_ff  <= rkind_in;
      ridx_ff   <= ridx_in;
      rvalue_ff <= rvalue_in;
      rfk_ff    <= rfk_in;
      rfs_ff    <= rfs_in;
      rlast_ff  <= rlast_in;
   end

   assign rsp_valid       = rvalid_ff;
   assign rsp_kind        = rkind_ff;
   assign rsp_item_index  = ridx_ff;
   assign rsp_item_value  = rvalue_ff;
   assign rsp_frame_kind  = rfk_ff;
   assign rsp_in_failsafe = rfs_ff;
   assign rsp_last_of_run = rlast_ff;

   // only channel and link-stat jobs run past their first item
   `RCLFR_ASSERT_IMP(a_multi_kind, clock, reset, busy_ff && (idx_ff != '0), (hdr_ff.kind == rclfr_pkg::KIND_CHANNEL) || (hdr_ff.kind == rclfr_pkg::KIND_LINK_STAT), "multi-item job of a single-item kind")

   // an item that is not the last of its run belongs to a frame unpack
   `RCLFR_ASSERT_IMP(a_run_kind, clock, reset, rvalid_ff && !rlast_ff, (rkind_ff == rclfr_pkg::KIND_CHANNEL) || (rkind_ff == rclfr_pkg::KIND_LINK_STAT), "open run on a single-item kind")

   // failsafe change is a lone item with no frame type
   `RCLFR_ASSERT_IMP(a_fs_item, clock, reset, rvalid_ff && (rkind_ff == rclfr_pkg::KIND_FAILSAFE), rlast_ff && (rfk_ff == 8'h00) && (ridx_ff == '0), "bad failsafe item")

   // a popped job is being worked on next cycle
   `RCLFR_ASSERT_NXT(a_pop_busy, clock, reset, pop, busy_ff && (idx_ff == '0), "pop did not start a job")

endmodule

// File: bench/rc_link_frame_receiver_tb.sv
// self-checking testbench of the rc link frame receiver
`timescale 1ns / 1ps

module rc_link_frame_receiver_tb;
   import rclfr_pkg::*;

   localparam int BUF_BYTES      = BUFFER_BYTES_DEF;
   localparam int SETTLE_CYCLES  = 10;    // slack for a job to show its results
   localparam int HOLD_CYCLES    = 200;   // long receiver hold-off, fills the job queue
   localparam int WATCHDOG_LIMIT = 2000;  // cycles with no item moving on either side
   localparam int PHASE_ITEMS    = 50;
   localparam int DIR_COUNT      = 23;
   localparam int DIR_PHASE1     = 6;     // first directed row run under the second setting

   // one result item as the block should deliver it
   typedef struct packed {
      kind_type    kind;
      logic [3:0]  index;
      logic [11:0] value;
      logic [7:0]  frame_kind;
      logic        fs;
      logic        last;
   } rc_result_t;

   // one directed row; typed rows carry their single result written out by hand
   typedef struct packed {
      op_type     op;
      logic [7:0] data;
      bit         crc_tail;   // send the running crc in place of data
      bit         typed;
      kind_type   x_kind;
      logic [7:0] x_fk;
      bit         x_fs;
   } dir_row_t;

   localparam dir_row_t DIR_ROWS [DIR_COUNT] = '{
      // reset setting: frames of length one, the type byte doubles as the crc byte
      '{OP_BYTE, 8'h00, 1'b0, 1'b0, KIND_OTHER,     8'h00, 1'b0},
      '{OP_BYTE, 8'h01, 1'b0, 1'b0, KIND_OTHER,     8'h00, 1'b0},
      '{OP_BYTE, 8'h00, 1'b0, 1'b1, KIND_OTHER,     8'h00, 1'b0},  // crc of nothing is zero
      '{OP_BYTE, 8'hC8, 1'b0, 1'b0, KIND_OTHER,     8'h00, 1'b0},
      '{OP_BYTE, 8'h01, 1'b0, 1'b0, KIND_OTHER,     8'h00, 1'b0},
      '{OP_BYTE, 8'hFF, 1'b0, 1'b1, KIND_CRC_ERROR, 8'hFF, 1'b0},  // 0xff is no crc of nothing
      // min gap 0, failsafe past 1 tick of silence, own address 0xc8
      '{OP_TICK, 8'h00, 1'b0, 1'b0, KIND_OTHER,     8'h00, 1'b0},
      '{OP_TICK, 8'h00, 1'b0, 1'b1, KIND_FAILSAFE,  8'h00, 1'b1},
      '{OP_BYTE, 8'hFF, 1'b0, 1'b0, KIND_OTHER,     8'h00, 1'b0},  // gap clears, new frame
      '{OP_BYTE, 8'h00, 1'b0, 1'b0, KIND_OTHER,     8'h00, 1'b0},  // declared length zero
      '{OP_BYTE, 8'h16, 1'b0, 1'b0, KIND_OTHER,     8'h00, 1'b0},
      '{OP_TICK, 8'h00, 1'b0, 1'b1, KIND_FAILSAFE,  8'h00, 1'b0},  // first tick after a byte
      '{OP_BYTE, 8'hC8, 1'b0, 1'b0, KIND_OTHER,     8'h00, 1'b0},  // gap drops the dead frame
      '{OP_BYTE, 8'h02, 1'b0, 1'b0, KIND_OTHER,     8'h00, 1'b0},
      '{OP_BYTE, 8'h16, 1'b0, 1'b0, KIND_OTHER,     8'h00, 1'b0},
      '{OP_BYTE, 8'h00, 1'b1, 1'b0, KIND_OTHER,     8'h00, 1'b0},  // short rc frame, 16 channels
      '{OP_BYTE, 8'h00, 1'b0, 1'b0, KIND_OTHER,     8'h00, 1'b0},
      '{OP_BYTE, 8'h02, 1'b0, 1'b0, KIND_OTHER,     8'h00, 1'b0},
      '{OP_BYTE, 8'h14, 1'b0, 1'b0, KIND_OTHER,     8'h00, 1'b0},
      '{OP_BYTE, 8'h00, 1'b1, 1'b0, KIND_OTHER,     8'h00, 1'b0},  // short link-stat frame
      '{OP_BYTE, 8'h55, 1'b0, 1'b0, KIND_OTHER,     8'h00, 1'b0},
      '{OP_BYTE, 8'h01, 1'b0, 1'b0, KIND_OTHER,     8'h00, 1'b0},
      '{OP_BYTE, 8'h00, 1'b0, 1'b1, KIND_OTHER,     8'h00, 1'b0}   // good crc, foreign address
   };

   // clock, reset and block inputs, all known from time zero
   logic                 clock         = 1'b0;
   logic                 reset         = 1'b1;
   logic                 req_valid     = 1'b0;
   logic                 req_stall;
   logic                 req_operation = OP_BYTE;
   logic [7:0]           req_rx_byte   = 8'h00;
   logic                 rsp_valid;
   logic                 rsp_stall     = 1'b0;
   logic [2:0]           rsp_kind;
   logic [IDX_W-1:0]     rsp_item_index;
   logic [VALUE_W-1:0]   rsp_item_value;
   logic [7:0]           rsp_frame_kind;
   logic                 rsp_in_failsafe;
   logic                 rsp_last_of_run;
   logic                 csr_we        = 1'b0;
   logic [1:0]           csr_index     = CSR_MIN_GAP;
   logic [SILENCE_W-1:0] csr_wdata     = '0;

   // idling controls; the sender side is used only by the stimulus process
   bit tx_idle_on = 1'b1;
   bit rx_idle_on = 1'b1;
   bit hold_arm   = 1'b0;
   bit hold_done  = 1'b0;
   int stall_left = 0;

   int          fail_count  = 0;
   int          quiet_cycles = 0;
   int unsigned sent_count  = 0;

   // receiver state as the block should hold it
   logic [SILENCE_W-1:0] cfg_min_gap;
   logic [SILENCE_W-1:0] cfg_failsafe;
   logic [7:0]           cfg_addr;
   logic [7:0]           cfg_poly;
   logic [7:0]           frame_buf [0:BUF_BYTES-1];
   int unsigned          held;
   logic [7:0]           decl_len;
   logic [7:0]           crc_acc;
   logic [SILENCE_W-1:0] silence;
   logic                 fs_flag;

   rc_result_t item_results [$];     // results caused by the item just accepted
   rc_result_t awaited_results [$];  // results still to come out of the block

   rc_link_frame_receiver dut (
      .clock           (clock),
      .reset           (reset),
      .req_valid       (req_valid),
      .req_stall       (req_stall),
      .req_operation   (req_operation),
      .req_rx_byte     (req_rx_byte),
      .rsp_valid       (rsp_valid),
      .rsp_stall       (rsp_stall),
      .rsp_kind        (rsp_kind),
      .rsp_item_index  (rsp_item_index),
      .rsp_item_value  (rsp_item_value),
      .rsp_frame_kind  (rsp_frame_kind),
      .rsp_in_failsafe (rsp_in_failsafe),
      .rsp_last_of_run (rsp_last_of_run),
      .csr_we          (csr_we),
      .csr_index       (csr_index),
      .csr_wdata       (csr_wdata)
   );

   always begin
      #5 clock = 1'b1;
      #5 clock = 1'b0;
   end

   // ---------------------------------------------------------------- predictor

   function automatic logic [7:0] byte_at(input int unsigned p);
      return (p < BUF_BYTES) ? frame_buf[p] : 8'h00;
   endfunction

   function automatic void clear_frame();
      for (int i = 0; i < BUF_BYTES; i++) frame_buf[i] = 8'h00;
      held    = 0;
      crc_acc = 8'h00;
   endfunction

   // crc-8 msb first over one byte with the current polynomial
   function automatic logic [7:0] crc8_step(input logic [7:0] acc, input logic [7:0] data);
      logic [7:0] c;
      c = acc ^ data;
      repeat (8) c = {c[6:0], 1'b0} ^ (c[7] ? cfg_poly : 8'h00);
      return c;
   endfunction

   function automatic void note_result(input kind_type kind, input logic [3:0] idx,
                                       input logic [11:0] val, input logic [7:0] fk);
      item_results.push_back('{kind, idx, val, fk, fs_flag, 1'b0});
   endfunction

   // a complete frame: crc check, then channels, link stats or one status
   function automatic void close_frame();
      logic [7:0]  ftype;
      logic [7:0]  addr;
      logic [23:0] w;
      int unsigned off;
      int unsigned pos;
      int unsigned xv;
      bit          addr_ok;
      ftype   = byte_at(2);
      addr    = byte_at(0);
      addr_ok = (addr == ADDR_BROADCAST) || (addr == cfg_addr);
      if (crc_acc != byte_at(int'(decl_len) + 1)) begin
         note_result(KIND_CRC_ERROR, 4'd0, 12'd0, ftype);
      end else if (addr_ok && ftype == TYPE_RC_CHANNELS) begin
         for (int ch = 0; ch < NUM_CHANNELS_DEF; ch++) begin
            off = ch * CHANNEL_BITS_DEF;
            pos = FIRST_PAYLOAD + off / 8;
            w   = {byte_at(pos + 2), byte_at(pos + 1), byte_at(pos)};
            xv  = (int'(w) >> (off % 8)) & 32'h7FF;
            note_result(KIND_CHANNEL, 4'(ch), 12'(xv * 5 / 8 + int'(CHANNEL_OFFSET)), ftype);
         end
      end else if (addr_ok && ftype == TYPE_LINK_STATS) begin
         for (int i = 0; i < LINK_STAT_BYTES_DEF; i++)
            note_result(KIND_LINK_STAT, 4'(i), {4'h0, byte_at(FIRST_PAYLOAD + i)}, ftype);
      end else begin
         note_result(KIND_OTHER, 4'd0, 12'd0, ftype);
      end
      clear_frame();
   endfunction

   // effect of one accepted item, results land in item_results
   function automatic void decode_item(input op_type op, input logic [7:0] data);
      logic        nf;
      int unsigned pos;
      rc_result_t  r;
      item_results.delete();
      if (op == OP_TICK) begin
         if (silence != SILENCE_MAX) silence = silence + 1'b1;
         nf = (silence > cfg_failsafe);
         if (nf != fs_flag) begin
            fs_flag = nf;
            note_result(KIND_FAILSAFE, 4'd0, 12'd0, 8'h00);
         end
      end else begin
         if (silence > cfg_min_gap) clear_frame();
         if (held >= BUF_BYTES) clear_frame();
         silence        = '0;
         pos            = held;
         frame_buf[pos] = data;
         held++;
         if (pos == 2) decl_len = frame_buf[1];
         if (pos >= 2) begin
            if (pos <= decl_len) crc_acc = crc8_step(crc_acc, data);
            if (held == int'(decl_len) + 2) close_frame();
         end
      end
      if (item_results.size() != 0) begin
         r      = item_results.pop_back();
         r.last = 1'b1;
         item_results.push_back(r);
      end
   endfunction

   // ---------------------------------------------------------------- input side

   // offer one item, hold it until taken, then predict what it causes
   task automatic send_item(input op_type op, input logic [7:0] data, input bit typed,
                            input rc_result_t typed_res);
      if (tx_idle_on && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 9)) @(posedge clock);
      end
      req_valid     <= 1'b1;
      req_operation <= op;
      // the byte is don't-care on a tick, keep it moving
      req_rx_byte   <= (op == OP_TICK) ? 8'($urandom_range(0, 255)) : data;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sent_count++;
      decode_item(op, data);
      if (typed) awaited_results.push_back(typed_res);
      else foreach (item_results[k]) awaited_results.push_back(item_results[k]);
   endtask

   task automatic send_byte(input logic [7:0] data);
      send_item(OP_BYTE, data, 1'b0, '0);
   endtask

   task automatic send_tick();
      send_item(OP_TICK, 8'h00, 1'b0, '0);
   endtask

   // stop offering, let every awaited result come out, then let the block settle
   task automatic wait_for_drain();
      req_valid <= 1'b0;
      while (awaited_results.size() != 0) @(posedge clock);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   // write all four registers while the block is idle
   task automatic set_registers(input logic [SILENCE_W-1:0] gap, input logic [SILENCE_W-1:0] fs,
                                input logic [7:0] addr, input logic [7:0] poly);
      wait_for_drain();
      csr_we    <= 1'b1;
      csr_index <= CSR_MIN_GAP;
      csr_wdata <= gap;
      @(posedge clock);
      csr_index <= CSR_FAILSAFE;
      csr_wdata <= fs;
      @(posedge clock);
      csr_index <= CSR_OWN_ADDR;
      csr_wdata <= {12'h000, addr};
      @(posedge clock);
      csr_index <= CSR_CRC_POLY;
      csr_wdata <= {12'h000, poly};
      @(posedge clock);
      csr_we       <= 1'b0;
      cfg_min_gap  = gap;
      cfg_failsafe = fs;
      cfg_addr     = addr;
      cfg_poly     = poly;
   endtask

   // one well-formed frame with random content, now and then a corrupt crc
   task automatic send_frame();
      logic [7:0]  addr;
      logic [7:0]  ftype;
      int unsigned len;
      int unsigned fill;
      int unsigned pick;
      // get back to a frame boundary first: by a gap, or by filling up to overflow
      if (held != 0) begin
         if (cfg_min_gap < 40) repeat (cfg_min_gap + 1) send_tick();
         else while (held != 0 && held < BUF_BYTES) send_byte(8'($urandom_range(0, 255)));
      end
      case ($urandom_range(0, 3))
         0:       addr = ADDR_BROADCAST;
         1, 2:    addr = cfg_addr;
         default: addr = 8'($urandom_range(0, 255));
      endcase
      pick = $urandom_range(0, 9);
      if (pick < 6) begin
         ftype = TYPE_RC_CHANNELS;
         len   = ($urandom_range(0, 4) != 0) ? 24 : $urandom_range(1, 30);
      end else if (pick < 8) begin
         ftype = TYPE_LINK_STATS;
         len   = ($urandom_range(0, 4) != 0) ? 12 : $urandom_range(1, 14);
      end else begin
         ftype = 8'($urandom_range(0, 255));
         len   = $urandom_range(1, 12);
      end
      fill = $urandom_range(0, 5);
      send_byte(addr);
      send_byte(8'(len));
      send_byte(ftype);
      if (len > 1) begin
         for (int p = 3; p <= len; p++) begin
            if ($urandom_range(0, 39) == 0) send_tick();
            // mostly random payload, sometimes all ones or all zeros for channel extremes
            case (fill)
               0:       send_byte(8'hFF);
               1:       send_byte(8'h00);
               default: send_byte(8'($urandom_range(0, 255)));
            endcase
         end
         if ($urandom_range(0, 7) == 0) send_byte(crc_acc ^ 8'($urandom_range(1, 255)));
         else send_byte(crc_acc);
      end
   endtask

   // mostly whole frames, plus tick runs, stray bytes and broken headers
   task automatic run_random_phase(input bit with_overflow, input bit with_hold);
      int unsigned first;
      int unsigned pick;
      first = sent_count;
      if (with_overflow) begin
         // endless declared length: the 65th byte clears the store and starts over
         send_byte(8'hC8);
         send_byte(8'hFF);
         send_byte(TYPE_RC_CHANNELS);
         repeat (BUF_BYTES) send_byte(8'($urandom_range(0, 255)));
      end
      while (sent_count - first < PHASE_ITEMS) begin
         if (with_hold && sent_count - first > PHASE_ITEMS / 3) hold_arm <= 1'b1;
         pick = $urandom_range(0, 9);
         // stray bytes could never be flushed out with a huge min gap
         if (pick >= 8 && cfg_min_gap >= 40) pick = 0;
         if (pick < 6) begin
            send_frame();
         end else if (pick < 8) begin
            repeat ($urandom_range(1, 10)) send_tick();
         end else if (pick == 8) begin
            repeat ($urandom_range(1, 4)) send_byte(8'($urandom_range(0, 255)));
         end else begin
            send_byte(8'($urandom_range(0, 255)));
            send_byte(($urandom_range(0, 1) == 0) ? 8'h00 : 8'($urandom_range(62, 255)));
            send_byte(8'($urandom_range(0, 255)));
            repeat ($urandom_range(0, 5)) send_byte(8'($urandom_range(0, 255)));
         end
      end
   endtask

   // ---------------------------------------------------------------- stimulus

   initial begin
      dir_row_t row;
      // predictor starts from the reset setting
      cfg_min_gap  = MIN_GAP_RESET;
      cfg_failsafe = FAILSAFE_RESET;
      cfg_addr     = OWN_ADDR_RESET;
      cfg_poly     = CRC_POLY_RESET;
      clear_frame();
      decl_len = 8'h00;
      silence  = '0;
      fs_flag  = 1'b0;

      repeat (11) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // directed rows: reset setting first, then a tight gap and failsafe setting
      for (int i = 0; i < DIR_COUNT; i++) begin
         if (i == DIR_PHASE1) set_registers(20'd0, 20'd1, 8'hC8, CRC_POLY_RESET);
         row = DIR_ROWS[i];
         send_item(row.op, row.crc_tail ? crc_acc : row.data, row.typed,
                   '{row.x_kind, 4'd0, 12'd0, row.x_fk, row.x_fs, 1'b1});
      end

      // random part over several settings, the extremes among them
      set_registers(20'd10, 20'd6, 8'($urandom_range(1, 254)), CRC_POLY_RESET);
      run_random_phase(1'b1, 1'b1);
      set_registers(20'd0, 20'd0, 8'hFF, 8'h00);
      run_random_phase(1'b0, 1'b0);
      set_registers(20'hFFFFF, 20'hFFFFF, 8'h00, 8'hFF);
      run_random_phase(1'b0, 1'b0);
      // last stretch runs at full speed on both sides
      tx_idle_on = 1'b0;
      rx_idle_on <= 1'b0;
      set_registers(20'($urandom_range(2, 30)), 20'($urandom_range(2, 30)),
                    8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)));
      run_random_phase(1'b0, 1'b0);

      wait_for_drain();
      if (fail_count == 0) $display("simulation ok");
      else $display("simulation failed");
      $finish;
   end

   // ---------------------------------------------------------------- result side

   // random stall bursts, plus one long hold-off so the job queue backs up
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall  <= 1'b0;
         stall_left = 0;
      end else if (hold_arm && !hold_done) begin
         hold_done  = 1'b1;
         stall_left = HOLD_CYCLES;
         rsp_stall  <= 1'b1;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_stall <= 1'b1;
      end else if (rx_idle_on && $urandom_range(0, 5) == 0) begin
         stall_left = $urandom_range(0, 8);
         rsp_stall  <= 1'b1;
      end else begin
         rsp_stall <= 1'b0;
      end
   end

   task automatic check_field(input string name, input logic [11:0] want,
                              input logic [11:0] got);
      if (want !== got) begin
         $error("%s mismatch: expected %0d, got %0d", name, want, got);
         fail_count++;
      end
   endtask

   // every taken result item against the oldest one awaited
   always @(posedge clock) begin : result_check
      rc_result_t want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (awaited_results.size() == 0) begin
            $error("result item with nothing awaited: kind %0d index %0d value %0d",
                   rsp_kind, rsp_item_index, rsp_item_value);
            fail_count++;
         end else begin
            want = awaited_results.pop_front();
            check_field("kind", want.kind, rsp_kind);
            check_field("item_index", want.index, rsp_item_index);
            check_field("item_value", want.value, rsp_item_value);
            check_field("frame_kind", want.frame_kind, rsp_frame_kind);
            check_field("in_failsafe", want.fs, rsp_in_failsafe);
            check_field("last_of_run", want.last, rsp_last_of_run);
         end
      end
   end

   // give up when neither side has moved an item for too long
   always @(posedge clock) begin
      if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("simulation failed");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

endmodule

// File: rc_link_frame_receiver.f
+incdir+src
src/rclfr_pkg.sv
src/rclfr_queue.sv
src/rclfr_front.sv
src/rclfr_back.sv
src/rc_link_frame_receiver.sv
bench/rc_link_frame_receiver_tb.sv
